// ----- hw/rtl/flm_pkg.sv -----
// Shared constants, types and field widths for the frame loss monitor.
package flm_pkg;

    localparam int unsigned MaxFrameBytes = 128;
    localparam logic [31:0] MagicReset = 32'h5241_4e54;
    localparam logic [7:0]  TagAt      = 8'd10;
    localparam logic [7:0]  SeqAt      = 8'd14;
    localparam logic [7:0]  SeqEnd     = 8'd17;
    localparam logic [7:0]  MinLen     = 8'd19;
    localparam logic [19:0] PpmScale   = 20'd1000000;
    localparam int unsigned DivSteps   = 20;

    // controller -> datapath
    typedef struct packed {
        logic take_byte;   // frame byte accepted
        logic take_fail;   // failure event accepted
        logic div_start;   // begin loss division
        logic div_step;    // one restoring step
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
    } t_status;

endpackage

// ----- hw/rtl/flm_datapath.sv -----
// Datapath: frame parser, statistics registers and serial ppm divider.
module flm_datapath #(
    parameter int unsigned MAX_FRAME_BYTES = flm_pkg::MaxFrameBytes
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  flm_pkg::t_cmd    i_cmd,
    output flm_pkg::t_status o_status,
    input  logic [31:0]      i_magic,
    input  logic [7:0]       i_byte_value,
    input  logic             i_last_byte,
    input  logic             i_fail_aborted,
    output logic [31:0]      o_received_count,
    output logic [31:0]      o_foreign_count,
    output logic [31:0]      o_span_count,
    output logic [31:0]      o_lost_count,
    output logic [19:0]      o_loss_ppm,
    output logic [31:0]      o_worst_gap_len,
    output logic [31:0]      o_disorder_count,
    output logic [31:0]      o_failure_count,
    output logic [31:0]      o_abort_count,
    output logic [7:0]       o_seen_length,
    output logic             o_heard_any
);
    import flm_pkg::*;

    localparam logic [7:0] PosMax = 8'(MAX_FRAME_BYTES - 1);

    logic [7:0]  r_pos, r_len, r_own_len;
    logic [31:0] r_tag, r_seq, r_recv, r_foreign, r_first, r_last, r_gap;
    logic [31:0] r_disorder, r_failed, r_aborted;
    logic        r_have;
    // divider; lost * 1e6 top 32 bits are below span, so they preload the remainder
    logic [19:0] r_num;      // low 20 product bits, shifted out MSB first
    logic [32:0] r_rem;
    logic [19:0] r_quo;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;

    logic [31:0] seq_now, tag_now, gap_now, span_now, lost_now;
    logic [51:0] prod_now;
    logic [7:0]  len_now;
    logic        own;
    logic        rem_ge;
    logic [32:0] rem_sh, rem_sub;

    always_comb begin
        len_now = (r_pos == 8'd0) ? i_byte_value : r_len;
        tag_now = (r_pos >= TagAt && r_pos < SeqAt) ? {r_tag[23:0], i_byte_value} : r_tag;
        seq_now = (r_pos >= SeqAt && r_pos <= SeqEnd) ? {r_seq[23:0], i_byte_value} : r_seq;
        own     = !(r_pos < SeqEnd || len_now < MinLen || tag_now != i_magic);
        gap_now = seq_now - r_last - 32'd1;
        span_now = r_have ? (r_last - r_first + 32'd1) : 32'd0;
        lost_now = (span_now > r_recv) ? (span_now - r_recv) : 32'd0;
        prod_now = 52'(lost_now) * 52'(PpmScale);
        rem_sh  = {r_rem[31:0], r_num[19]};
        rem_ge  = (rem_sh >= {1'b0, r_den});
        rem_sub = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_len <= '0; r_tag <= '0; r_seq <= '0;
            r_recv <= '0; r_foreign <= '0; r_first <= '0; r_last <= '0;
            r_have <= 1'b0; r_gap <= '0; r_disorder <= '0; r_own_len <= '0;
            r_failed <= '0; r_aborted <= '0; r_cnt <= '0;
        end else begin
            if (i_cmd.take_fail) begin
                r_failed <= r_failed + 32'd1;
                if (i_fail_aborted) begin
                    r_aborted <= r_aborted + 32'd1;
                end
            end
            if (i_cmd.take_byte) begin
                r_len <= len_now;
                r_tag <= tag_now;
                r_seq <= seq_now;
                if (i_last_byte) begin
                    r_pos <= '0;
                    if (!own) begin
                        r_foreign <= r_foreign + 32'd1;
                    end else begin
                        r_own_len <= len_now;
                        if (!r_have) begin
                            r_have  <= 1'b1;
                            r_first <= seq_now;
                            r_last  <= seq_now;
                            r_recv  <= 32'd1;
                        end else begin
                            r_recv <= r_recv + 32'd1;
                            if (seq_now > r_last) begin
                                r_last <= seq_now;
                                if (gap_now > r_gap) begin
                                    r_gap <= gap_now;
                                end
                            end else begin
                                r_disorder <= r_disorder + 32'd1;
                            end
                        end
                    end
                end else if (r_pos < PosMax) begin
                    r_pos <= r_pos + 8'd1;
                end
            end
            if (i_cmd.div_start) begin
                r_cnt <= 6'(DivSteps);
            end else if (i_cmd.div_step && r_cnt != 6'd0) begin
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    // restoring division; quotient < 2^20 since lost < span
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_num <= prod_now[19:0];
            r_rem <= {1'b0, prod_now[51:20]};
            r_quo <= '0;
            r_den <= span_now;
        end else if (i_cmd.div_step && r_cnt != 6'd0) begin
            r_num <= {r_num[18:0], 1'b0};
            if (rem_ge) begin
                r_rem <= rem_sub;
                r_quo <= {r_quo[18:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[18:0], 1'b0};
            end
        end
    end

    assign o_status.div_done = (r_cnt == 6'd0);
    assign o_received_count  = r_recv;
    assign o_foreign_count   = r_foreign;
    assign o_span_count      = span_now;
    assign o_lost_count      = lost_now;
    assign o_loss_ppm        = (r_den == 32'd0) ? 20'd0 : r_quo;
    assign o_worst_gap_len   = r_gap;
    assign o_disorder_count  = r_disorder;
    assign o_failure_count   = r_failed;
    assign o_abort_count     = r_aborted;
    assign o_seen_length     = r_own_len;
    assign o_heard_any       = r_have;
endmodule

// ----- hw/rtl/flm_ctrl.sv -----
// Controller: request sequencing, divider control and output handshake.
module flm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_req_type,
    input  logic             i_last_byte,
    output flm_pkg::t_cmd    o_cmd,
    input  flm_pkg::t_status i_status,
    output logic             o_valid,
    input  logic             i_stall
);
    import flm_pkg::*;

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StArm  = 2'd1;
    localparam logic [1:0] StDiv  = 2'd2;
    localparam logic [1:0] StOut  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       acc;

    assign o_stall = (r_state != StIdle);
    assign acc     = i_valid && !o_stall;
    assign o_valid = (r_state == StOut);

    always_comb begin
        o_cmd.take_byte = acc && !i_req_type;
        o_cmd.take_fail = acc && i_req_type;
        o_cmd.div_start = (r_state == StArm);
        o_cmd.div_step  = (r_state == StDiv);
        n_state = r_state;
        unique case (r_state)
            StIdle: if (acc && (i_req_type || i_last_byte)) n_state = StArm;
            StArm:  n_state = StDiv;
            StDiv:  if (i_status.div_done) n_state = StOut;
            StOut:  if (!i_stall) n_state = StIdle;
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ----- hw/rtl/frame_loss_monitor.sv -----
// Top level of the frame loss monitor.
// Frame bytes are accepted back to back. A request that ends a frame, or a receive
// failure event, produces one report: the statistics update in the accepting
// cycle, the StArm state loads the divider, then a 20-step restoring divider
// works out loss in ppm and the report is offered; the input stalls until the
// report is taken. The magic register may be written only while idle.
module frame_loss_monitor #(
    parameter int unsigned MAX_FRAME_BYTES = flm_pkg::MaxFrameBytes
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [7:0]  i_byte_value,
    input  logic        i_last_byte,
    input  logic        i_fail_aborted,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_received_count,
    output logic [31:0] o_foreign_count,
    output logic [31:0] o_span_count,
    output logic [31:0] o_lost_count,
    output logic [19:0] o_loss_ppm,
    output logic [31:0] o_worst_gap_len,
    output logic [31:0] o_disorder_count,
    output logic [31:0] o_failure_count,
    output logic [31:0] o_abort_count,
    output logic [7:0]  o_seen_length,
    output logic        o_heard_any
);
    import flm_pkg::*;

    t_cmd        cmd;
    t_status     status;
    logic [31:0] r_magic;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= MagicReset;
        end else if (i_cfg_valid) begin
            r_magic <= i_cfg_data;
        end
    end

    flm_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_req_type, .i_last_byte,
        .o_cmd(cmd), .i_status(status), .o_valid, .i_stall
    );

    flm_datapath #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_status(status), .i_magic(r_magic),
        .i_byte_value, .i_last_byte, .i_fail_aborted,
        .o_received_count, .o_foreign_count, .o_span_count, .o_lost_count,
        .o_loss_ppm, .o_worst_gap_len, .o_disorder_count, .o_failure_count,
        .o_abort_count, .o_seen_length, .o_heard_any
    );

    // input is held off while a report is pending
    a_stall_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input open with report pending");
    // a failure event always raises the failure counter
    a_fail_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.take_fail |=> o_failure_count == $past(o_failure_count) + 32'd1)
        else $error("failure count missed");
    // ppm never exceeds one million
    a_ppm_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_loss_ppm <= PpmScale) else $error("ppm out of range");
endmodule

// ----- verif/frame_loss_monitor_test.sv -----
// Self-checking test of the frame loss monitor: directed and random frames and failure events.
module frame_loss_monitor_test;
    import flm_pkg::*;

    // One report as the block emits it.
    typedef struct {
        logic [31:0] rcv, frn, span, lost;
        logic [19:0] ppm;
        logic [31:0] gap, dis, fail, abrt;
        logic [7:0]  len;
        logic        heard;
    } t_report;

    // Predicted monitor state plus the queue of reports still owed.
    class loss_board;
        logic [31:0] magic;
        logic [7:0]  pos, len_hold;
        logic [31:0] tag, seq, rcv, frn, first, last, gap, dis, fail, abrt;
        logic [7:0]  own_len;
        logic        have;
        t_report     owed[$];
        int          errors;

        function void clear();
            magic = MagicReset;
            pos = 0; len_hold = 0; tag = 0; seq = 0; rcv = 0; frn = 0;
            first = 0; last = 0; gap = 0; dis = 0; fail = 0; abrt = 0;
            own_len = 0; have = 0; errors = 0;
            owed.delete();
        endfunction

        function void snapshot();
            t_report r;
            logic [31:0] sp, lo;
            logic [63:0] q;
            sp = 0; lo = 0; q = 0;
            if (have) begin
                sp = last - first + 32'd1;
                lo = (sp > rcv) ? sp - rcv : 32'd0;
                if (sp != 0) q = (64'(lo) * 64'd1000000) / 64'(sp);
            end
            r.rcv = rcv; r.frn = frn; r.span = sp; r.lost = lo; r.ppm = q[19:0];
            r.gap = gap; r.dis = dis; r.fail = fail; r.abrt = abrt;
            r.len = own_len; r.heard = have;
            owed.push_back(r);
        endfunction

        function void tally_frame(logic [7:0] fpos);
            logic [31:0] g;
            if (fpos < SeqEnd || len_hold < MinLen || tag != magic) begin
                frn++;
                return;
            end
            own_len = len_hold;
            if (!have) begin
                have = 1; first = seq; last = seq; rcv = 1;
                return;
            end
            rcv++;
            if (seq > last) begin
                g = seq - last - 32'd1;
                if (g > gap) gap = g;
                last = seq;
            end else begin
                dis++;
            end
        endfunction

        // Note one accepted request.
        function void note_request(logic rt, logic [7:0] b, logic lb, logic ab);
            logic [7:0] p;
            if (rt) begin
                fail++;
                if (ab) abrt++;
                snapshot();
                return;
            end
            p = pos;
            if (p == 0) len_hold = b;
            else if (p >= TagAt && p < SeqAt) tag = {tag[23:0], b};
            else if (p >= SeqAt && p <= SeqEnd) seq = {seq[23:0], b};
            if (lb) begin
                pos = 0;
                tally_frame(p);
                snapshot();
            end else if (p < MaxFrameBytes - 1) begin
                pos = p + 8'd1;
            end
        endfunction
    endclass

    logic        i_clk = 0, i_rst_n = 0;
    logic        i_valid = 0, i_req_type = 0, i_last_byte = 0, i_fail_aborted = 0;
    logic [7:0]  i_byte_value = 0;
    logic        i_cfg_valid = 0, i_stall = 0;
    logic [31:0] i_cfg_data = 0;
    logic        o_stall, o_cfg_ready, o_valid, o_heard_any;
    logic [31:0] o_received_count, o_foreign_count, o_span_count, o_lost_count;
    logic [31:0] o_worst_gap_len, o_disorder_count, o_failure_count, o_abort_count;
    logic [19:0] o_loss_ppm;
    logic [7:0]  o_seen_length;

    frame_loss_monitor uut (.*);

    always #2 i_clk = ~i_clk;

    loss_board board = new();
    int  quiet_cycles = 0;
    int  idle_pct = 6;
    bit  done_all = 0;
    localparam int QuietLimit = 20000;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        board.errors++;
    endtask

    // Output side: random stall, check each accepted report.
    always @(posedge i_clk) begin
        t_report w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (board.owed.size() == 0) begin
                report_mismatch("unexpected report", 0, 0);
            end else begin
                w = board.owed.pop_front();
                if (o_received_count !== w.rcv) report_mismatch("received", o_received_count, w.rcv);
                if (o_foreign_count !== w.frn) report_mismatch("foreign", o_foreign_count, w.frn);
                if (o_span_count !== w.span) report_mismatch("span", o_span_count, w.span);
                if (o_lost_count !== w.lost) report_mismatch("lost", o_lost_count, w.lost);
                if (o_loss_ppm !== w.ppm) report_mismatch("ppm", 32'(o_loss_ppm), 32'(w.ppm));
                if (o_worst_gap_len !== w.gap) report_mismatch("gap", o_worst_gap_len, w.gap);
                if (o_disorder_count !== w.dis) report_mismatch("disorder", o_disorder_count, w.dis);
                if (o_failure_count !== w.fail) report_mismatch("failures", o_failure_count, w.fail);
                if (o_abort_count !== w.abrt) report_mismatch("aborts", o_abort_count, w.abrt);
                if (o_seen_length !== w.len) report_mismatch("length", 32'(o_seen_length), 32'(w.len));
                if (o_heard_any !== w.heard) report_mismatch("heard", 32'(o_heard_any), 32'(w.heard));
            end
        end
        // Watchdog: cycles with nothing accepted on any channel.
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge i_clk)
        i_stall <= ($urandom_range(99) < idle_pct);

    // Send one request; waits for acceptance at a rising edge. Valid stays up
    // afterwards so the next request can follow back to back.
    task automatic send_request(logic rt, logic [7:0] b, logic lb, logic ab);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1; i_req_type <= rt; i_byte_value <= b;
        i_last_byte <= lb; i_fail_aborted <= ab;
        do @(posedge i_clk); while (o_stall);
        board.note_request(rt, b, lb, ab);
        @(negedge i_clk);
    endtask

    // Drop valid, wait for all reports, then write the magic.
    task automatic write_magic(logic [31:0] m);
        i_valid <= 0;
        while (board.owed.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        i_cfg_valid <= 1; i_cfg_data <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.magic = m;
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    // One frame; the caller's length, tag and byte count make it own, bad magic, short length or truncated.
    task automatic send_frame(logic [7:0] flen, logic [31:0] tagv, logic [31:0] seqv,
                              int nbytes);
        logic [7:0] b;
        for (int k = 0; k < nbytes; k++) begin
            b = 8'($urandom);
            if (k == 0) b = flen;
            else if (k >= 10 && k < 14) b = tagv[8*(13-k) +: 8];
            else if (k >= 14 && k < 18) b = seqv[8*(17-k) +: 8];
            // An occasional failure event in the middle of a frame.
            if (k > 0 && $urandom_range(49) == 0)
                send_request(1, 8'($urandom), 1'($urandom), 1'($urandom));
            send_request(0, b, k == nbytes - 1, 1'($urandom));
        end
    endtask

    logic [31:0] seq_now;

    task automatic random_phase(int count);
        int kind, nb;
        logic [31:0] sq;
        for (int f = 0; f < count; f++) begin
            kind = $urandom_range(99);
            nb = ($urandom_range(9) == 0) ? $urandom_range(19, 140) : $urandom_range(19, 24);
            case ($urandom_range(9))
                0: sq = seq_now - $urandom_range(3);
                1: sq = seq_now + $urandom_range(1000);
                2: sq = $urandom;
                default: sq = seq_now + $urandom_range(1, 3);
            endcase
            if (kind < 70) begin
                send_frame(8'($urandom_range(19, 255)), board.magic, sq, nb);
                seq_now = sq;
            end else if (kind < 78) begin
                send_frame(8'($urandom_range(19, 255)), board.magic ^ (32'd1 << $urandom_range(31)),
                           sq, nb);
            end else if (kind < 84) begin
                send_frame(8'($urandom_range(18)), board.magic, sq, nb);
            end else if (kind < 92) begin
                send_frame(8'($urandom), board.magic, sq, $urandom_range(1, 18));
            end else begin
                send_request(1, 8'($urandom), 1'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        board.clear();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: failure before any frame, truncations, extremes.
        send_request(1, 8'hff, 1, 1);
        send_request(1, 8'h00, 0, 0);
        send_frame(8'd19, MagicReset, 32'h0000_0005, 19);
        send_frame(8'd255, MagicReset, 32'h0000_0009, 19);
        send_frame(8'd18, MagicReset, 32'h0000_000a, 19);
        send_frame(8'd20, MagicReset, 32'h0000_0003, 20);
        send_frame(8'd20, ~MagicReset, 32'h0000_000b, 20);
        send_frame(8'd30, MagicReset, 32'h0000_000c, 17);
        send_frame(8'd30, MagicReset, 32'h0000_000d, 18);
        send_frame(8'd200, MagicReset, 32'hffff_ffff, 140);
        send_request(0, 8'h00, 1, 0);

        seq_now = 32'h100;
        write_magic(32'h0000_0000);
        send_frame(8'd19, 32'h0, 32'h0, 19);
        random_phase(7);
        write_magic(32'hffff_ffff);
        random_phase(7);
        // Long stretch with no idling.
        idle_pct = 0;
        write_magic($urandom);
        random_phase(7);
        idle_pct = 6;
        write_magic(MagicReset);
        random_phase(7);

        i_valid <= 0;
        while (board.owed.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/flm_pkg.sv
hw/rtl/flm_datapath.sv
hw/rtl/flm_ctrl.sv
hw/rtl/frame_loss_monitor.sv
verif/frame_loss_monitor_test.sv
